// ===== hdl/stereo_tap_meter_and_recorder_top_macros.svh =====
// Assertion macros shared by the stereo tap meter and recorder RTL.
`ifndef STEREO_TAP_METER_AND_RECORDER_TOP_MACROS_SVH
`define STEREO_TAP_METER_AND_RECORDER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Checks that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== hdl/stmr_pkg.sv =====
// Package with the types, constants and helpers of the stereo tap meter and recorder.
package stmr_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int MAX_BLOCK   = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int MAG_BITS    = SAMPLE_BITS - 1;
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int SUM_BITS    = 60;
    localparam int CNT_BITS    = 48;
    localparam int FILL_BITS   = 13;
    localparam int POS_BITS    = $clog2(RING_DEPTH);
    localparam int BLK_BITS    = $clog2(MAX_BLOCK + 1);
    localparam int STEP_BITS   = $clog2(SUM_BITS);
    localparam int CFG_IDX_BITS = 8;

    localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_MODE      = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RING_CAPACITY = 8'd1;

    // Commands.
    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Tap modes.
    localparam logic [1:0] MODE_METER   = 2'd0;
    localparam logic [1:0] MODE_STICKY  = 2'd1;
    localparam logic [1:0] MODE_CAPTURE = 2'd2;

    typedef struct packed {
        logic [1:0]                    command;
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          last_in_block;
    } t_in;

    typedef struct packed {
        logic                          meter_ready;
        logic [MAG_BITS-1:0]           peak_left;
        logic [MAG_BITS-1:0]           peak_right;
        logic [MAG_BITS-1:0]           rms_left;
        logic [MAG_BITS-1:0]           rms_right;
        logic                          popped_valid;
        logic signed [SAMPLE_BITS-1:0] popped_left;
        logic signed [SAMPLE_BITS-1:0] popped_right;
        logic [CNT_BITS-1:0]           sequence_count;
        logic [CNT_BITS-1:0]           dropped_count;
        logic                          overflow_flag;
        logic [FILL_BITS-1:0]          fill_level;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SQL, S_SQR, S_ACCR, S_POP,
        S_RMSL, S_WAITL, S_RMSR, S_WAITR, S_OUT
    } t_state;

    typedef enum logic [1:0] {M_IDLE, M_DIV, M_SQRT} t_math_state;

    // Absolute value of a sample, saturated to the largest positive code.
    function automatic logic [MAG_BITS-1:0] magnitude(input logic signed [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS-1:0] m;
        m = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
        return m[SAMPLE_BITS-1] ? MAG_MAX : m[MAG_BITS-1:0];
    endfunction

endpackage

// ===== hdl/stmr_math.sv =====
// Iterative divide and square root unit: floor(sqrt(sum / count)), saturated.
module stmr_math (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [stmr_pkg::SUM_BITS-1:0] i_sum,
    input  logic [stmr_pkg::BLK_BITS-1:0] i_count,
    output logic                          o_done,
    output logic [stmr_pkg::MAG_BITS-1:0] o_root
);
    import stmr_pkg::*;

    localparam int DIV_LAST  = SUM_BITS - 1;
    localparam int SQRT_LAST = SUM_BITS / 2 - 1;

    t_math_state              r_state;
    logic [STEP_BITS-1:0]     r_cnt;
    logic [SUM_BITS-1:0]      r_num;
    logic [BLK_BITS-1:0]      r_rem;
    logic [BLK_BITS-1:0]      r_div;
    logic [SUM_BITS-1:0]      r_x;
    logic [SUM_BITS-1:0]      r_res;
    logic [SUM_BITS-1:0]      r_bit;
    logic                     r_done;
    logic [MAG_BITS-1:0]      r_root;

    logic [BLK_BITS:0]        rem_sh;
    logic                     qbit;
    logic [BLK_BITS-1:0]      rem_nx;
    logic [SUM_BITS-1:0]      num_nx;
    logic [SUM_BITS-1:0]      trial;
    logic                     take;

    // One restoring division step and one square root step per cycle.
    always_comb begin
        rem_sh = {r_rem, r_num[SUM_BITS-1]};
        qbit   = (rem_sh >= {1'b0, r_div});
        rem_nx = qbit ? BLK_BITS'(rem_sh - {1'b0, r_div}) : rem_sh[BLK_BITS-1:0];
        num_nx = {r_num[SUM_BITS-2:0], qbit};
        trial  = r_res + r_bit;
        take   = (r_x >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_sum;
                        r_div   <= i_count;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_DIV;
                    end
                end
                M_DIV: begin
                    r_num <= num_nx;
                    r_rem <= rem_nx;
                    if (r_cnt == STEP_BITS'(DIV_LAST)) begin
                        r_x     <= num_nx;
                        r_res   <= '0;
                        r_bit   <= SUM_BITS'(1) << (SUM_BITS - 2);
                        r_cnt   <= '0;
                        r_state <= M_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                M_SQRT: begin
                    logic [SUM_BITS-1:0] res_nx;
                    res_nx = take ? ((r_res >> 1) + r_bit) : (r_res >> 1);
                    if (take) r_x <= r_x - trial;
                    r_res <= res_nx;
                    r_bit <= r_bit >> 2;
                    if (r_cnt == STEP_BITS'(SQRT_LAST)) begin
                        r_root  <= (res_nx > SUM_BITS'(MAG_MAX)) ? MAG_MAX
                                                                 : res_nx[MAG_BITS-1:0];
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/stereo_tap_meter_and_recorder_top.sv =====
// Top level of the stereo tap meter and recorder: sequencer, state and ring memory.
// A meter frame that closes a block also runs the shared divide and square root
// unit: 60 division and 30 root steps for each channel in turn.
// One item is in work at a time; a new transfer is taken after the result is taken.
// Synchronous active-low reset clears all counters, pointers and accumulators;
// ring contents are undefined until written.
`include "stereo_tap_meter_and_recorder_top_macros.svh"
module stereo_tap_meter_and_recorder_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  stmr_pkg::t_in                          i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output stmr_pkg::t_out                         o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [stmr_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [stmr_pkg::FILL_BITS-1:0]         i_cfg_data
);
    import stmr_pkg::*;

    // Configuration and runtime state.
    logic [1:0]              r_mode;
    logic [FILL_BITS-1:0]    r_cap;
    t_state                  r_state, n_state;
    t_in                     r_item;
    logic [MAG_BITS-1:0]     r_peak_l, r_peak_r;
    logic [SUM_BITS-1:0]     r_sum_l, r_sum_r;
    logic [SQ_BITS-1:0]      r_sq;
    logic [BLK_BITS-1:0]     r_blk;
    logic [POS_BITS-1:0]     r_wr_pos, r_rd_pos;
    logic [FILL_BITS-1:0]    r_held;
    logic [CNT_BITS-1:0]     r_seq, r_drop;
    logic                    r_ovf;
    logic                    r_ready_m, r_pv;
    logic [MAG_BITS-1:0]     r_pl, r_pr, r_rl, r_rr;
    logic signed [SAMPLE_BITS-1:0] r_popl, r_popr;

    // Ring memory.
    logic signed [SAMPLE_BITS-1:0] mem_l [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] mem_r [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_l, r_rd_r;
    logic                          wr_en;

    logic [FILL_BITS-1:0]    cap_now;
    logic [MAG_BITS-1:0]     mag_l, mag_r, mag_sel;
    logic [SQ_BITS-1:0]      sq;
    logic [SUM_BITS:0]       add_ext;
    logic [SUM_BITS-1:0]     sum_sel, sum_new;
    logic                    blocked;
    logic                    math_start, math_done;
    logic [MAG_BITS-1:0]     math_root;

    assign o_cfg_ready = 1'b1;

    // Clamped capacity, magnitudes and the shared squaring multiplier.
    always_comb begin
        cap_now = r_cap;
        if (r_cap == '0) cap_now = FILL_BITS'(1);
        if (r_cap > FILL_BITS'(RING_DEPTH)) cap_now = FILL_BITS'(RING_DEPTH);
        mag_l   = magnitude(r_item.left_sample);
        mag_r   = magnitude(r_item.right_sample);
        mag_sel = (r_state == S_SQL) ? mag_l : mag_r;
        sq      = mag_sel * mag_sel;
        sum_sel = (r_state == S_SQR) ? r_sum_l : r_sum_r;
        add_ext = {1'b0, sum_sel} + {{(SUM_BITS + 1 - SQ_BITS){1'b0}}, r_sq};
        sum_new = add_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : add_ext[SUM_BITS-1:0];
        blocked = ((r_mode == MODE_STICKY) && r_ovf) || (r_held >= cap_now);
        wr_en   = (r_state == S_EXEC) && (r_item.command == CMD_FRAME)
                  && ((r_mode == MODE_STICKY) || (r_mode == MODE_CAPTURE)) && !blocked;
    end

    function automatic logic [POS_BITS-1:0] advance(input logic [POS_BITS-1:0] pos,
                                                    input logic [FILL_BITS-1:0] cap);
        logic [FILL_BITS-1:0] nx;
        nx = FILL_BITS'(pos) + 1'b1;
        return (nx >= cap) ? '0 : nx[POS_BITS-1:0];
    endfunction

    // Ring write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_l[r_wr_pos] <= r_item.left_sample;
            mem_r[r_wr_pos] <= r_item.right_sample;
        end
        r_rd_l <= mem_l[r_rd_pos];
        r_rd_r <= mem_r[r_rd_pos];
    end

    // Sequencer next state and handshake outputs.
    always_comb begin
        n_state     = r_state;
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        math_start  = (r_state == S_RMSL) || (r_state == S_RMSR);
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_OUT;
                if (r_item.command == CMD_FRAME && r_mode == MODE_METER) n_state = S_SQL;
                if (r_item.command == CMD_POP && r_held != '0) n_state = S_POP;
            end
            S_SQL:   n_state = S_SQR;
            S_SQR:   n_state = S_ACCR;
            S_ACCR:  n_state = r_item.last_in_block ? S_RMSL : S_OUT;
            S_POP:   n_state = S_OUT;
            S_RMSL:  n_state = S_WAITL;
            S_WAITL: if (math_done) n_state = S_RMSR;
            S_RMSR:  n_state = S_WAITR;
            S_WAITR: if (math_done) n_state = S_OUT;
            S_OUT:   if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Item register and squared magnitude register.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_item <= i_in_data;
        if (r_state == S_SQL || r_state == S_SQR) r_sq <= sq;
    end

    // Configuration writes and runtime state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_METER;
            r_cap     <= FILL_BITS'(RING_DEPTH);
            r_peak_l  <= '0;
            r_peak_r  <= '0;
            r_sum_l   <= '0;
            r_sum_r   <= '0;
            r_blk     <= '0;
            r_wr_pos  <= '0;
            r_rd_pos  <= '0;
            r_held    <= '0;
            r_seq     <= '0;
            r_drop    <= '0;
            r_ovf     <= 1'b0;
            r_ready_m <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_TAP_MODE) r_mode <= i_cfg_data[1:0];
                else if (i_cfg_index == REG_RING_CAPACITY) r_cap <= i_cfg_data;
            end
            case (r_state)
                S_EXEC: begin
                    r_ready_m <= 1'b0;
                    r_pv      <= 1'b0;
                    r_pl <= '0; r_pr <= '0; r_rl <= '0; r_rr <= '0;
                    r_popl <= '0; r_popr <= '0;
                    if (r_item.command == CMD_FRAME
                        && (r_mode == MODE_STICKY || r_mode == MODE_CAPTURE)) begin
                        if (blocked) begin
                            if (r_drop != {CNT_BITS{1'b1}}) r_drop <= r_drop + 1'b1;
                            r_ovf <= 1'b1;
                        end else begin
                            r_wr_pos <= advance(r_wr_pos, cap_now);
                            r_held   <= r_held + 1'b1;
                            r_seq    <= r_seq + 1'b1;
                        end
                    end else if (r_item.command == CMD_CLEAR) begin
                        r_peak_l <= '0; r_peak_r <= '0;
                        r_sum_l  <= '0; r_sum_r  <= '0;
                        r_blk    <= '0;
                        r_wr_pos <= '0; r_rd_pos <= '0; r_held <= '0;
                        r_seq    <= '0; r_drop   <= '0; r_ovf  <= 1'b0;
                    end
                end
                S_SQL: if (mag_l > r_peak_l) r_peak_l <= mag_l;
                S_SQR: begin
                    r_sum_l <= sum_new;
                    if (mag_r > r_peak_r) r_peak_r <= mag_r;
                end
                S_ACCR: begin
                    r_sum_r <= sum_new;
                    if (r_blk < BLK_BITS'(MAX_BLOCK)) r_blk <= r_blk + 1'b1;
                end
                S_POP: begin
                    r_pv     <= 1'b1;
                    r_popl   <= r_rd_l;
                    r_popr   <= r_rd_r;
                    r_rd_pos <= advance(r_rd_pos, cap_now);
                    r_held   <= r_held - 1'b1;
                end
                S_WAITL: if (math_done) r_rl <= math_root;
                S_WAITR: begin
                    if (math_done) begin
                        r_rr      <= math_root;
                        r_ready_m <= 1'b1;
                        r_pl      <= r_peak_l;
                        r_pr      <= r_peak_r;
                        r_seq     <= r_seq + 1'b1;
                        r_peak_l  <= '0; r_peak_r <= '0;
                        r_sum_l   <= '0; r_sum_r  <= '0;
                        r_blk     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    stmr_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (math_start),
        .i_sum   ((r_state == S_RMSL) ? r_sum_l : r_sum_r),
        .i_count (r_blk),
        .o_done  (math_done),
        .o_root  (math_root)
    );

    // Result assembly: status fields show the state after the item.
    always_comb begin
        o_out_data.meter_ready    = r_ready_m;
        o_out_data.peak_left      = r_pl;
        o_out_data.peak_right     = r_pr;
        o_out_data.rms_left       = r_rl;
        o_out_data.rms_right      = r_rr;
        o_out_data.popped_valid   = r_pv;
        o_out_data.popped_left    = r_popl;
        o_out_data.popped_right   = r_popr;
        o_out_data.sequence_count = r_seq;
        o_out_data.dropped_count  = r_drop;
        o_out_data.overflow_flag  = r_ovf;
        o_out_data.fill_level     = r_held;
    end

    `ASSERT_IMPLIES(a_fill_bound, i_clk, i_rst_n, 1'b1, r_held <= FILL_BITS'(RING_DEPTH))
    `ASSERT_IMPLIES(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, o_in_ready && i_in_valid, !o_in_ready)
    `ASSERT_IMPLIES(a_done_waiting, i_clk, i_rst_n, math_done,
                    r_state == S_WAITL || r_state == S_WAITR)

endmodule

// ===== tb/tb_stereo_tap_meter_and_recorder_top.sv =====
// Self-checking testbench for the stereo tap meter and ring recorder.
module tb_stereo_tap_meter_and_recorder_top;
    timeunit 1ns;
    timeprecision 1ps;
    import stmr_pkg::*;

    localparam int IDLE_LIMIT  = 6000;
    localparam int DRAIN_GAP   = 250;
    localparam int LONG_HOLD   = 400;
    localparam logic [22:0] PEAK_TOP = 23'h7FFFFF;
    localparam logic [59:0] SUM_TOP  = {60{1'b1}};
    localparam logic [47:0] CNT_TOP  = {48{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in in_data = '0;
    logic out_valid;
    logic out_ready = 1'b1;
    t_out out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [FILL_BITS-1:0] cfg_data = '0;

    stereo_tap_meter_and_recorder_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Predicted block state and register copies.
    logic [1:0]  mode_q = MODE_METER;
    logic [12:0] cap_reg = 13'd4096;
    logic [22:0] peak_l, peak_r;
    logic [59:0] sq_l, sq_r;
    int          blk_frames;
    logic [23:0] ring_l [0:RING_DEPTH-1];
    logic [23:0] ring_r [0:RING_DEPTH-1];
    int          wr_pos, rd_pos, held;
    logic [47:0] seq_cnt, drop_cnt;
    logic        ovf;

    t_in  frame_cmds[$];
    t_out pending_reports[$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    bit   in_fire = 1'b0;
    bit   quiet = 1'b0;
    bit   long_hold_req = 1'b0;
    bit   long_hold_done = 1'b0;

    // Absolute value of a Q1.23 sample, clipped to the positive full scale.
    function automatic logic [22:0] abs_q23(logic [23:0] s);
        logic [23:0] m;
        m = s[23] ? (24'd0 - s) : s;
        return m[23] ? PEAK_TOP : m[22:0];
    endfunction

    function automatic logic [59:0] add_clip(logic [59:0] acc, logic [45:0] sq);
        logic [60:0] t;
        t = {1'b0, acc} + {15'd0, sq};
        return t[60] ? SUM_TOP : t[59:0];
    endfunction

    // Floor of the square root of the mean square, clipped to full scale.
    function automatic logic [22:0] block_rms(logic [59:0] acc, int n);
        longint unsigned x, r, t;
        x = acc / n;
        r = 0;
        for (int b = 30; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return (r > PEAK_TOP) ? PEAK_TOP : r[22:0];
    endfunction

    function automatic int ring_size();
        if (cap_reg < 1) return 1;
        if (cap_reg > RING_DEPTH) return RING_DEPTH;
        return cap_reg;
    endfunction

    function automatic int ring_next(int pos);
        return (pos + 1 >= ring_size()) ? 0 : pos + 1;
    endfunction

    function automatic void clear_runtime();
        peak_l = '0; peak_r = '0; sq_l = '0; sq_r = '0; blk_frames = 0;
        wr_pos = 0; rd_pos = 0; held = 0; seq_cnt = '0; drop_cnt = '0; ovf = 1'b0;
    endfunction

    // Works out the status report caused by one accepted command.
    function automatic void predict_report(t_in it);
        t_out e;
        logic [22:0] ml, mr;
        int w;
        e = '0;
        if (it.command == CMD_FRAME) begin
            if (mode_q == MODE_METER) begin
                ml = abs_q23(it.left_sample);
                mr = abs_q23(it.right_sample);
                if (ml > peak_l) peak_l = ml;
                if (mr > peak_r) peak_r = mr;
                sq_l = add_clip(sq_l, 46'(ml) * 46'(ml));
                sq_r = add_clip(sq_r, 46'(mr) * 46'(mr));
                if (blk_frames < MAX_BLOCK) blk_frames++;
                if (it.last_in_block) begin
                    e.meter_ready = 1'b1;
                    e.peak_left = peak_l;
                    e.peak_right = peak_r;
                    e.rms_left = block_rms(sq_l, blk_frames);
                    e.rms_right = block_rms(sq_r, blk_frames);
                    seq_cnt = seq_cnt + 1'b1;
                    peak_l = '0; peak_r = '0; sq_l = '0; sq_r = '0; blk_frames = 0;
                end
            end else if (mode_q == MODE_STICKY || mode_q == MODE_CAPTURE) begin
                if ((mode_q == MODE_STICKY && ovf) || held >= ring_size()) begin
                    if (drop_cnt != CNT_TOP) drop_cnt++;
                    ovf = 1'b1;
                end else begin
                    w = wr_pos % RING_DEPTH;
                    ring_l[w] = it.left_sample;
                    ring_r[w] = it.right_sample;
                    wr_pos = ring_next(w);
                    held++;
                    seq_cnt = seq_cnt + 1'b1;
                end
            end
        end else if (it.command == CMD_POP) begin
            if (held > 0) begin
                w = rd_pos % RING_DEPTH;
                e.popped_valid = 1'b1;
                e.popped_left = ring_l[w];
                e.popped_right = ring_r[w];
                rd_pos = ring_next(w);
                held--;
            end
        end else if (it.command == CMD_CLEAR) begin
            clear_runtime();
        end
        e.sequence_count = seq_cnt;
        e.dropped_count = drop_cnt;
        e.overflow_flag = ovf;
        e.fill_level = FILL_BITS'(held);
        pending_reports.push_back(e);
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Transfers are observed at the rising edge; this drives prediction and checking.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n) begin
            in_fire <= in_valid && in_ready;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_TAP_MODE) mode_q = cfg_data[1:0];
                else if (cfg_index == REG_RING_CAPACITY) cap_reg = cfg_data;
            end
            if (in_valid && in_ready) predict_report(in_data);
            if (out_valid && out_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("status report with no command outstanding");
                    errors++;
                end else begin
                    e = pending_reports.pop_front();
                    check_field("meter_ready", e.meter_ready, out_data.meter_ready);
                    check_field("peak_left", e.peak_left, out_data.peak_left);
                    check_field("peak_right", e.peak_right, out_data.peak_right);
                    check_field("rms_left", e.rms_left, out_data.rms_left);
                    check_field("rms_right", e.rms_right, out_data.rms_right);
                    check_field("popped_valid", e.popped_valid, out_data.popped_valid);
                    check_field("popped_left", e.popped_left, out_data.popped_left);
                    check_field("popped_right", e.popped_right, out_data.popped_right);
                    check_field("sequence_count", e.sequence_count,
                                out_data.sequence_count);
                    check_field("dropped_count", e.dropped_count, out_data.dropped_count);
                    check_field("overflow_flag", e.overflow_flag, out_data.overflow_flag);
                    check_field("fill_level", e.fill_level, out_data.fill_level);
                end
            end
            // Watchdog on cycles without any transfer.
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // Command driver with random idle bursts between transfers.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left--;
            end else if (frame_cmds.size() > 0) begin
                in_data <= frame_cmds.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 6);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Report receiver: random stall bursts and one long hold-off.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 5);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic [23:0] any_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic void add_cmd(logic [1:0] c, logic [23:0] l, logic [23:0] r, logic lb);
        t_in it;
        it.command = c;
        it.left_sample = l;
        it.right_sample = r;
        it.last_in_block = lb;
        frame_cmds.push_back(it);
    endfunction

    task automatic wait_drained();
        while (frame_cmds.size() != 0 || in_valid || pending_reports.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [FILL_BITS-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Empties the ring so that a capacity change never exposes unwritten entries.
    task automatic settle_and_configure(logic [1:0] m, logic [12:0] c);
        wait_drained();
        for (int k = 0; k < held; k++) add_cmd(CMD_POP, any_sample(), any_sample(), 1'b0);
        wait_drained();
        repeat (DRAIN_GAP) @(negedge i_clk);
        write_reg(REG_TAP_MODE, FILL_BITS'(m));
        write_reg(REG_RING_CAPACITY, c);
    endtask

    // Random traffic suited to the current mode.
    task automatic random_phase(int count);
        int n, len, pick;
        n = 0;
        while (n < count) begin
            if (mode_q == MODE_METER) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                for (int k = 1; k <= len; k++)
                    add_cmd(CMD_FRAME, any_sample(), any_sample(), k == len);
                n += len;
                pick = $urandom_range(0, 19);
                if (pick == 0) add_cmd(CMD_POP, any_sample(), any_sample(), 1'($urandom));
                else if (pick == 1)
                    add_cmd(CMD_CLEAR, any_sample(), any_sample(), 1'($urandom));
                else if (pick == 2) add_cmd(2'd3, any_sample(), any_sample(), 1'($urandom));
                n += (pick < 3) ? 1 : 0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) add_cmd(CMD_FRAME, any_sample(), any_sample(), 1'($urandom));
                else if (pick < 94)
                    add_cmd(CMD_POP, any_sample(), any_sample(), 1'($urandom));
                else if (pick < 97)
                    add_cmd(CMD_CLEAR, any_sample(), any_sample(), 1'($urandom));
                else add_cmd(2'd3, any_sample(), any_sample(), 1'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        clear_runtime();
        for (int k = 0; k < RING_DEPTH; k++) begin
            ring_l[k] = '0;
            ring_r[k] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full-scale and most negative samples, single-frame blocks,
        // empty pop, unused command and clear in the middle of a block.
        add_cmd(CMD_FRAME, 24'h7FFFFF, 24'h800000, 1'b0);
        add_cmd(CMD_FRAME, 24'hFFFFFF, 24'h000000, 1'b1);
        add_cmd(CMD_FRAME, 24'h800000, 24'h7FFFFF, 1'b1);
        add_cmd(CMD_FRAME, 24'h000000, 24'h000000, 1'b1);
        add_cmd(CMD_POP, 24'h0, 24'h0, 1'b0);
        add_cmd(2'd3, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        add_cmd(CMD_FRAME, 24'd123, -24'sd456, 1'b0);
        add_cmd(CMD_CLEAR, 24'h0, 24'h0, 1'b0);
        add_cmd(CMD_FRAME, 24'd5, 24'd5, 1'b1);
        settle_and_configure(MODE_STICKY, 13'd1);
        add_cmd(CMD_FRAME, 24'h7FFFFF, 24'h800000, 1'b0);
        add_cmd(CMD_FRAME, 24'h123456, 24'h654321, 1'b0);
        add_cmd(CMD_POP, 24'h0, 24'h0, 1'b0);
        add_cmd(CMD_FRAME, 24'h000001, 24'h000002, 1'b0);
        add_cmd(CMD_POP, 24'h0, 24'h0, 1'b0);
        add_cmd(CMD_CLEAR, 24'h0, 24'h0, 1'b0);
        add_cmd(CMD_FRAME, 24'h800000, 24'h7FFFFF, 1'b1);
        add_cmd(CMD_POP, 24'h0, 24'h0, 1'b0);

        // Random phases across modes and capacities, extremes included.
        random_phase(110);
        long_hold_req = 1'b1;
        settle_and_configure(MODE_CAPTURE, 13'd3);
        random_phase(130);
        settle_and_configure(MODE_METER, 13'd4096);
        random_phase(150);
        settle_and_configure(MODE_STICKY, 13'd6);
        write_reg(8'hFF, FILL_BITS'($urandom));
        random_phase(130);
        settle_and_configure(2'd3, 13'd2);
        random_phase(60);
        settle_and_configure(MODE_CAPTURE, 13'd4096);
        random_phase(140);
        settle_and_configure(MODE_CAPTURE, 13'd1);
        random_phase(120);
        settle_and_configure(MODE_METER, 13'd17);
        random_phase(130);
        settle_and_configure(MODE_STICKY, 13'd4095);
        quiet = 1'b1;
        random_phase(120);

        wait_drained();
        repeat (DRAIN_GAP) @(posedge i_clk);
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
